// ===== hw/rtl/fsdm_pkg.sv =====
// shared constants and stage payload type for the floored signed divider
`default_nettype none

package fsdm_pkg;

   // arithmetic width; operand bits above this width are ignored
   localparam int unsigned DATA_WIDTH = 64;

   // width of the operand and result ports
   localparam int unsigned WORD_WIDTH = 64;

   // operation codes carried in the kind field
   localparam logic KIND_QUOTIENT = 1'b0;
   localparam logic KIND_MODULO   = 1'b1;

   // payload carried from cell to cell down the divider chain
   typedef struct packed {
      logic                  kind;
      logic                  differ;
      logic                  div_neg;
      logic                  div_by_zero;
      logic [DATA_WIDTH-1:0] divisor_mag;
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] quo;
   } fsdm_stage_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fsdm_prep.sv =====
// input stage: operand sign split and magnitudes
`default_nettype none

module fsdm_prep
   import fsdm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire logic                   in_valid,
   input  wire logic                   in_kind,
   input  wire logic [WORD_WIDTH-1:0]  in_dividend,
   input  wire logic [WORD_WIDTH-1:0]  in_divisor,
   output logic                        out_valid,
   output fsdm_stage_type              out_stage
);

   logic                  valid_ff;
   fsdm_stage_type        stage_ff;
   fsdm_stage_type        stage_in;
   logic [DATA_WIDTH-1:0] dividend_w;
   logic [DATA_WIDTH-1:0] divisor_w;
   logic                  dividend_neg;
   logic                  divisor_neg;

   // low bits only, then magnitudes (most negative maps onto 2^(w-1))
   always_comb begin
      dividend_w   = in_dividend[DATA_WIDTH-1:0];
      divisor_w    = in_divisor[DATA_WIDTH-1:0];
      dividend_neg = dividend_w[DATA_WIDTH-1];
      divisor_neg  = divisor_w[DATA_WIDTH-1];
      stage_in.kind        = in_kind;
      stage_in.differ      = dividend_neg ^ divisor_neg;
      stage_in.div_neg     = divisor_neg;
      stage_in.div_by_zero = (divisor_w == '0);
      stage_in.divisor_mag = divisor_neg ? (DATA_WIDTH'(0) - divisor_w) : divisor_w;
      stage_in.rem         = '0;
      stage_in.quo         = dividend_neg ? (DATA_WIDTH'(0) - dividend_w) : dividend_w;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fsdm_cell.sv =====
// one restoring division cell: one quotient bit per stage
`default_nettype none

module fsdm_cell
   import fsdm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           adv,
   input  wire logic           in_valid,
   input  wire fsdm_stage_type in_stage,
   output logic                out_valid,
   output fsdm_stage_type      out_stage
);

   logic                  valid_ff;
   fsdm_stage_type        stage_ff;
   fsdm_stage_type        stage_in;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   trial;

   // shift in next dividend bit and try the subtraction
   always_comb begin
      shifted  = {in_stage.rem, in_stage.quo[DATA_WIDTH-1]};
      trial    = shifted - {1'b0, in_stage.divisor_mag};
      stage_in = in_stage;
      stage_in.rem = trial[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      stage_in.quo = {in_stage.quo[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fsdm_out.sv =====
// output stage: floored sign fix-up, result register and stall control
`default_nettype none

module fsdm_out
   import fsdm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire fsdm_stage_type         in_stage,
   input  wire logic                   rsp_stall,
   output logic                        adv,
   output logic                        rsp_valid,
   output logic signed [WORD_WIDTH-1:0] rsp_value,
   output logic                        rsp_div_by_zero
);

   logic                         rsp_valid_ff;
   logic signed [WORD_WIDTH-1:0] value_ff;
   logic signed [WORD_WIDTH-1:0] value_in;
   logic                         dbz_ff;
   logic                         rem_nz;
   logic                         fix;
   logic [DATA_WIDTH-1:0]        quot_res;
   logic [DATA_WIDTH-1:0]        mod_res;
   logic signed [DATA_WIDTH-1:0] res;

   // whole chain moves unless a result is held by the receiver
   assign adv = !(rsp_valid_ff && rsp_stall);

   // floored correction of quotient and remainder
   always_comb begin
      rem_nz = |in_stage.rem;
      fix    = in_stage.differ && rem_nz;
      if (!in_stage.differ) begin
         quot_res = in_stage.quo;
      end else if (rem_nz) begin
         quot_res = ~in_stage.quo;
      end else begin
         quot_res = DATA_WIDTH'(0) - in_stage.quo;
      end
      if (in_stage.div_neg) begin
         mod_res = fix ? (in_stage.rem - in_stage.divisor_mag)
                       : (DATA_WIDTH'(0) - in_stage.rem);
      end else begin
         mod_res = fix ? (in_stage.divisor_mag - in_stage.rem) : in_stage.rem;
      end
      if (in_stage.div_by_zero) begin
         res = '0;
      end else if (in_stage.kind == KIND_MODULO) begin
         res = mod_res;
      end else begin
         res = quot_res;
      end
      value_in = WORD_WIDTH'(res);
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= in_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         value_ff <= value_in;
         dbz_ff   <= in_stage.div_by_zero;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = value_ff;
   assign rsp_div_by_zero = dbz_ff;

   // a zero divisor always reports a zero value
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dbz_ff |-> value_ff == '0)
      else $error("divide by zero transaction with nonzero value");

   // a nonzero floored modulo carries the divisor's sign
   a_mod_sign: assert property (@(posedge clock) disable iff (reset)
      in_valid && !in_stage.div_by_zero && in_stage.kind == KIND_MODULO && res != '0
      |-> res[DATA_WIDTH-1] == in_stage.div_neg)
      else $error("modulo sign differs from divisor sign");

   // operands of opposite sign never give a positive quotient
   a_quot_sign: assert property (@(posedge clock) disable iff (reset)
      in_valid && !in_stage.div_by_zero && in_stage.kind == KIND_QUOTIENT
      && in_stage.differ |-> res == '0 || res[DATA_WIDTH-1])
      else $error("positive quotient for operands of opposite sign");

   // the partial remainder stays below the divisor magnitude
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      in_valid && !in_stage.div_by_zero |-> in_stage.rem < in_stage.divisor_mag)
      else $error("remainder out of range at end of chain");

endmodule

`default_nettype wire

// ===== hw/rtl/floored_signed_divide_modulo.sv =====
// floored signed divide and modulo: a pipelined chain of restoring cells
//
// Usage:
//   Request channel req_valid / req_stall carries req_kind (0 quotient,
//   1 modulo), req_dividend and req_divisor, taken as DATA_WIDTH-bit
//   signed values. A transaction is taken when req_valid is high and
//   req_stall is low.
//   Response channel rsp_valid / rsp_stall returns rsp_value, the floored
//   quotient or modulo sign-extended to 64 bits, and rsp_div_by_zero,
//   which is set with a zero value when the divisor is zero.
//   The pipeline has one operand stage, one restoring cell per quotient
//   bit, and one fix-up and result register. Throughput is one
//   transaction per cycle while rsp_stall does not hold a response, set by
//   the cell chain which holds one transaction in every cell.
//   Responses leave in request order.
//   While a response is held by rsp_stall the whole chain freezes and
//   req_stall is raised; all in-flight transactions are kept.
//   Synchronous reset clears every stage valid; in-flight work is dropped.
`default_nettype none

module floored_signed_divide_modulo
   import fsdm_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_kind,
   input  wire logic signed [WORD_WIDTH-1:0] req_dividend,
   input  wire logic signed [WORD_WIDTH-1:0] req_divisor,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [WORD_WIDTH-1:0]     rsp_value,
   output logic                             rsp_div_by_zero
);

   logic           adv;
   logic           chain_valid [DATA_WIDTH+1];
   fsdm_stage_type chain_stage [DATA_WIDTH+1];

   assign req_stall = !adv;

   // operand stage
   fsdm_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .in_kind     (req_kind),
      .in_dividend (req_dividend),
      .in_divisor  (req_divisor),
      .out_valid   (chain_valid[0]),
      .out_stage   (chain_stage[0])
   );

   // one cell per quotient bit
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      fsdm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[i]),
         .in_stage  (chain_stage[i]),
         .out_valid (chain_valid[i+1]),
         .out_stage (chain_stage[i+1])
      );
   end

   // fix-up and result register
   fsdm_out u_out (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (chain_valid[DATA_WIDTH]),
      .in_stage        (chain_stage[DATA_WIDTH]),
      .rsp_stall       (rsp_stall),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_value       (rsp_value),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

endmodule

`default_nettype wire

// ===== bench/tb_floored_signed_divide_modulo.sv =====
`timescale 1ns / 100ps
// self-checking bench for the floored signed divide and modulo pipeline
module tb_floored_signed_divide_modulo
   import fsdm_pkg::*;
();

   localparam int LATENCY   = DATA_WIDTH + 2;
   localparam int LONG_HOLD = 4 * LATENCY + 40;
   localparam logic signed [WORD_WIDTH-1:0] WIDTH_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
   localparam logic signed [WORD_WIDTH-1:0] WIDTH_MIN = -WIDTH_MAX - 64'sd1;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] value;
      logic                  div_by_zero;
   } floored_outcome_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_kind;
   logic signed [WORD_WIDTH-1:0] req_dividend;
   logic signed [WORD_WIDTH-1:0] req_divisor;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [WORD_WIDTH-1:0] rsp_value;
   logic                         rsp_div_by_zero;

   // outcomes of accepted transactions, oldest first
   floored_outcome_type awaited_outcomes[$];
   int error_count;
   bit source_idle_on;
   bit sink_idle_on;
   bit long_hold_request;

   floored_signed_divide_modulo uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_dividend    (req_dividend),
      .req_divisor     (req_divisor),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard limit on run length
   initial begin
      #2_000_000;
      $display("tb_floored_signed_divide_modulo: errors");
      $finish;
   end

   // low DATA_WIDTH bits read as signed, sign-extended to the port width
   function automatic logic [WORD_WIDTH-1:0] to_data_width(input logic [WORD_WIDTH-1:0] v);
      logic signed [WORD_WIDTH-1:0] shifted;
      shifted = v << (WORD_WIDTH - DATA_WIDTH);
      return shifted >>> (WORD_WIDTH - DATA_WIDTH);
   endfunction

   // floored quotient or modulo on magnitudes, signs fixed up afterwards
   function automatic floored_outcome_type floored_divide(input logic kind,
                                                          input logic [WORD_WIDTH-1:0] dividend,
                                                          input logic [WORD_WIDTH-1:0] divisor);
      logic [WORD_WIDTH-1:0] num, den, num_mag, den_mag, quo, rem, mod_mag, raw;
      logic                  num_neg, den_neg, signs_differ;
      floored_outcome_type   outcome;
      num = to_data_width(dividend);
      den = to_data_width(divisor);
      if (den == '0) begin
         outcome.value       = '0;
         outcome.div_by_zero = 1'b1;
         return outcome;
      end
      num_neg      = num[WORD_WIDTH-1];
      den_neg      = den[WORD_WIDTH-1];
      signs_differ = num_neg ^ den_neg;
      num_mag      = num_neg ? '0 - num : num;
      den_mag      = den_neg ? '0 - den : den;
      quo          = num_mag / den_mag;
      rem          = num_mag % den_mag;
      if (kind == KIND_QUOTIENT) begin
         // round toward minus infinity when the signs differ and a remainder is left
         raw = signs_differ ? '0 - quo - ((rem != '0) ? 64'd1 : 64'd0) : quo;
      end else begin
         // modulo takes the sign of the divisor
         mod_mag = (signs_differ && rem != '0) ? den_mag - rem : rem;
         raw     = den_neg ? '0 - mod_mag : mod_mag;
      end
      outcome.value       = to_data_width(raw);
      outcome.div_by_zero = 1'b0;
      return outcome;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 88) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 70);
   endfunction

   // operand spread over full width, small values, extremes and magnitudes
   function automatic logic [WORD_WIDTH-1:0] random_operand();
      logic [WORD_WIDTH-1:0] word;
      word = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         3, 4: word = $signed(word) >>> $urandom_range(1, 62);
         5, 6: word = 64'($urandom_range(0, 40)) - 64'd20;
         7: begin
            case ($urandom_range(0, 4))
               0: word = WIDTH_MIN;
               1: word = WIDTH_MAX;
               2: word = '1;
               3: word = '0;
               default: word = 64'd1;
            endcase
         end
         8: word = word >> $urandom_range(0, 63);
         default: ;
      endcase
      return word;
   endfunction

   // offer one transaction and wait for it to be taken
   task automatic send_op(input logic kind, input logic [WORD_WIDTH-1:0] dividend,
                          input logic [WORD_WIDTH-1:0] divisor);
      int gap;
      gap = source_idle_on ? idle_length() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_dividend <= dividend;
      req_divisor  <= divisor;
      do @(posedge clock); while (req_stall);
      awaited_outcomes.push_back(floored_divide(kind, dividend, divisor));
   endtask

   // result side: random stalls, or one long hold on request
   initial begin : result_sink
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            hold = sink_idle_on ? idle_length() : 0;
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(negedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each response with the oldest outstanding transaction
   always @(posedge clock) begin : compare_responses
      floored_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_outcomes.size() == 0) begin
            $error("response with no transaction outstanding: rsp_value %0d rsp_div_by_zero %0b",
                   rsp_value, rsp_div_by_zero);
            error_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_value !== want.value) begin
               $error("rsp_value: expected %0d, actual %0d", $signed(want.value), rsp_value);
               error_count++;
            end
            if (rsp_div_by_zero !== want.div_by_zero) begin
               $error("rsp_div_by_zero: expected %0b, actual %0b", want.div_by_zero,
                      rsp_div_by_zero);
               error_count++;
            end
         end
      end
   end

   // corner cases: wrap, zero divisor, sign combinations, exact division, extremes
   task automatic test_directed();
      source_idle_on = 1'b1;
      sink_idle_on   = 1'b1;
      send_op(KIND_QUOTIENT, WIDTH_MIN, -1);
      send_op(KIND_MODULO, WIDTH_MIN, -1);
      send_op(KIND_QUOTIENT, 123, 0);
      send_op(KIND_MODULO, WIDTH_MIN, 0);
      send_op(KIND_QUOTIENT, 0, 0);
      send_op(KIND_MODULO, WIDTH_MAX, 0);
      for (int k = 0; k < 2; k++) begin
         for (int s = 0; s < 4; s++) begin
            send_op((k == 0) ? KIND_QUOTIENT : KIND_MODULO, s[0] ? -7 : 7, s[1] ? -2 : 2);
         end
      end
      send_op(KIND_QUOTIENT, -6, 3);
      send_op(KIND_MODULO, -6, 3);
      send_op(KIND_MODULO, 6, -3);
      send_op(KIND_QUOTIENT, WIDTH_MAX, WIDTH_MIN);
      send_op(KIND_MODULO, WIDTH_MAX, WIDTH_MIN);
      send_op(KIND_QUOTIENT, WIDTH_MIN, WIDTH_MAX);
      send_op(KIND_MODULO, WIDTH_MIN, WIDTH_MIN);
      send_op(KIND_QUOTIENT, 0, -5);
      send_op(KIND_MODULO, -1, WIDTH_MAX);
      send_op(KIND_QUOTIENT, WIDTH_MAX, 1);
   endtask

   // random operands with random gaps on both sides
   task automatic test_random_operands(input int count);
      int roll;
      logic kind;
      source_idle_on = 1'b1;
      sink_idle_on   = 1'b1;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         kind = ($urandom_range(0, 1) == 0) ? KIND_QUOTIENT : KIND_MODULO;
         if (roll < 3) send_op(kind, random_operand(), '0);
         else if (roll < 5) send_op(kind, WIDTH_MIN, -1);
         else send_op(kind, random_operand(), random_operand());
      end
   endtask

   // full rate with no idling on either side
   task automatic test_back_to_back(input int count);
      source_idle_on = 1'b0;
      sink_idle_on   = 1'b0;
      repeat (count) begin
         send_op(($urandom_range(0, 1) == 0) ? KIND_QUOTIENT : KIND_MODULO,
                 random_operand(), random_operand());
      end
   endtask

   // long result hold so the chain fills and the request side stalls
   task automatic test_stall_fill(input int count);
      source_idle_on    = 1'b0;
      sink_idle_on      = 1'b0;
      long_hold_request = 1'b1;
      repeat (count) begin
         send_op(($urandom_range(0, 1) == 0) ? KIND_QUOTIENT : KIND_MODULO,
                 random_operand(), random_operand());
      end
      while (long_hold_request) @(negedge clock);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_kind     = KIND_QUOTIENT;
      req_dividend = '0;
      req_divisor  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_operands(1450);
      test_back_to_back(200);
      test_stall_fill(200);

      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_floored_signed_divide_modulo: clean");
      end else begin
         $display("tb_floored_signed_divide_modulo: errors");
      end
      $finish;
   end

endmodule

// ===== floored_signed_divide_modulo.f =====
hw/rtl/fsdm_pkg.sv
hw/rtl/fsdm_prep.sv
hw/rtl/fsdm_cell.sv
hw/rtl/fsdm_out.sv
hw/rtl/floored_signed_divide_modulo.sv
bench/tb_floored_signed_divide_modulo.sv
